// ===== sv/bba_pkg.sv =====
// ---------------------------------------------------------------------------
// Bounding box accumulator package
// Shared widths, the box type, the back-end state type and the queue status
// struct.
// ---------------------------------------------------------------------------
package bba_pkg;

  localparam int COORD_BITS  = 16;
  localparam int SQ_BITS     = 2 * COORD_BITS;
  localparam int SUM_BITS    = SQ_BITS + 2;
  localparam int REM_BITS    = COORD_BITS + 2;
  localparam int CNT_BITS    = $clog2(COORD_BITS);
  localparam int IN_TDATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((7 * COORD_BITS + 7) / 8) * 8;

  // The queue depth must be a power of two so that the pointers wrap freely.
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] extent_t;

  typedef struct packed {
    coord_t max_z;
    coord_t max_y;
    coord_t max_x;
    coord_t min_z;
    coord_t min_y;
    coord_t min_x;
  } box_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_SUM,
    BK_ROOT,
    BK_OUT
  } back_state_e;

endpackage

// ===== sv/bounding_box_accumulator_top.sv =====
// Throughput: one vertex per cycle while the box queue is not full; the
// radius unit works on one mesh at a time with its bit-serial square root,
// and a two-entry box queue lets vertex intake run on while it works.
// Reset: asynchronous, active low; the next vertex after reset seeds a box.
// ---------------------------------------------------------------------------
// Bounding box accumulator
// Running per-axis minimum and maximum over a vertex stream, with a bounding
// sphere radius emitted for each mesh once its last vertex is taken.
// ---------------------------------------------------------------------------
module bounding_box_accumulator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // coord_x, coord_y, coord_z
  input  logic                             s_axis_tlast,   // last_vertex
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, sphere_radius
  output logic [bba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  bba_pkg::fifo_stat_t fifo_stat;
  bba_pkg::box_t       push_box, pop_box;
  logic                push, pop;

  bba_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .box_o         (push_box)
  );

  bba_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .box_i  (push_box),
    .pop_i  (pop),
    .box_o  (pop_box),
    .stat_o (fifo_stat)
  );

  bba_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .box_i         (pop_box),
    .fifo_stat_i   (fifo_stat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== sv/bba_front.sv =====
// ---------------------------------------------------------------------------
// Bounding box front end
// Takes one vertex per cycle while the queue is not full, widens the running
// box and hands the finished box of a mesh to the queue on its last vertex.
// ---------------------------------------------------------------------------
module bba_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // coord_x, coord_y, coord_z
  input  logic                             s_axis_tlast,   // last_vertex
  input  bba_pkg::fifo_stat_t              fifo_stat_i,
  output logic                             push_o,
  output bba_pkg::box_t                    box_o
);

  bba_pkg::box_t   box_q, box_d;
  logic            awaiting_q;
  logic            accept;
  bba_pkg::coord_t x, y, z;

  assign x = s_axis_tdata[bba_pkg::COORD_BITS-1:0];
  assign y = s_axis_tdata[2*bba_pkg::COORD_BITS-1:bba_pkg::COORD_BITS];
  assign z = s_axis_tdata[3*bba_pkg::COORD_BITS-1:2*bba_pkg::COORD_BITS];

  assign s_axis_tready = ~fifo_stat_i.full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    if (awaiting_q) begin
      box_d.min_x = x;
      box_d.min_y = y;
      box_d.min_z = z;
      box_d.max_x = x;
      box_d.max_y = y;
      box_d.max_z = z;
    end else begin
      box_d.min_x = (x < box_q.min_x) ? x : box_q.min_x;
      box_d.min_y = (y < box_q.min_y) ? y : box_q.min_y;
      box_d.min_z = (z < box_q.min_z) ? z : box_q.min_z;
      box_d.max_x = (x > box_q.max_x) ? x : box_q.max_x;
      box_d.max_y = (y > box_q.max_y) ? y : box_q.max_y;
      box_d.max_z = (z > box_q.max_z) ? z : box_q.max_z;
    end
  end

  assign push_o = accept & s_axis_tlast;
  assign box_o  = box_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q      <= '0;
      awaiting_q <= 1'b1;
    end else if (accept) begin
      box_q      <= box_d;
      awaiting_q <= s_axis_tlast;
    end
  end

endmodule

// ===== sv/bba_fifo.sv =====
// ---------------------------------------------------------------------------
// Bounding box queue
// Short first-in first-out store of finished boxes between the front end
// and the radius back end.
// ---------------------------------------------------------------------------
module bba_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bba_pkg::box_t        box_i,
  input  logic                 pop_i,
  output bba_pkg::box_t        box_o,
  output bba_pkg::fifo_stat_t  stat_o
);

  bba_pkg::box_t                   mem_q [bba_pkg::FIFO_DEPTH];
  logic [bba_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bba_pkg::FIFO_CNT_W-1:0]  count_q;
  logic                            do_push, do_pop;

  assign stat_o.full  = (count_q == bba_pkg::FIFO_CNT_W'(bba_pkg::FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign box_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= box_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bba_back.sv =====
// ---------------------------------------------------------------------------
// Bounding box back end
// Squares the box extents, sums them and takes the integer square root of a
// quarter of the sum one result bit per cycle, then holds the result request.
// ---------------------------------------------------------------------------
module bba_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bba_pkg::box_t                    box_i,
  input  bba_pkg::fifo_stat_t              fifo_stat_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, sphere_radius
  output logic [bba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  bba_pkg::back_state_e            state_q, state_d;
  bba_pkg::box_t                   box_q;
  bba_pkg::extent_t                ext_x_q, ext_y_q, ext_z_q;
  logic [bba_pkg::SQ_BITS-1:0]     sq_x_q, sq_y_q, sq_z_q;
  logic [bba_pkg::SQ_BITS-1:0]     rad_q;
  logic [bba_pkg::REM_BITS-1:0]    rem_q;
  logic [bba_pkg::COORD_BITS-1:0]  root_q;
  logic [bba_pkg::CNT_BITS-1:0]    cnt_q;

  logic [bba_pkg::COORD_BITS:0]    diff_x, diff_y, diff_z;
  logic [bba_pkg::SUM_BITS-1:0]    sum;
  logic [bba_pkg::REM_BITS-1:0]    rem_sh, trial;
  logic                            fits;

  // Extents are never negative and always fit in COORD_BITS unsigned bits.
  assign diff_x = {box_i.max_x[bba_pkg::COORD_BITS-1], box_i.max_x}
                - {box_i.min_x[bba_pkg::COORD_BITS-1], box_i.min_x};
  assign diff_y = {box_i.max_y[bba_pkg::COORD_BITS-1], box_i.max_y}
                - {box_i.min_y[bba_pkg::COORD_BITS-1], box_i.min_y};
  assign diff_z = {box_i.max_z[bba_pkg::COORD_BITS-1], box_i.max_z}
                - {box_i.min_z[bba_pkg::COORD_BITS-1], box_i.min_z};

  assign sum = bba_pkg::SUM_BITS'(sq_x_q) + bba_pkg::SUM_BITS'(sq_y_q)
             + bba_pkg::SUM_BITS'(sq_z_q);

  // One step of the restoring square root: the remainder stays below
  // two to the power COORD_BITS before the shift, so its top bits are spare.
  assign rem_sh = {rem_q[bba_pkg::REM_BITS-3:0], rad_q[bba_pkg::SQ_BITS-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      bba_pkg::BK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = bba_pkg::BK_SQUARE;
        end
      end
      bba_pkg::BK_SQUARE: state_d = bba_pkg::BK_SUM;
      bba_pkg::BK_SUM:    state_d = bba_pkg::BK_ROOT;
      bba_pkg::BK_ROOT: begin
        if (cnt_q == '0) begin
          state_d = bba_pkg::BK_OUT;
        end
      end
      bba_pkg::BK_OUT: begin
        if (m_axis_tready) begin
          state_d = bba_pkg::BK_IDLE;
        end
      end
      default: state_d = bba_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bba_pkg::BK_IDLE: begin
        if (pop_o) begin
          box_q   <= box_i;
          ext_x_q <= diff_x[bba_pkg::COORD_BITS-1:0];
          ext_y_q <= diff_y[bba_pkg::COORD_BITS-1:0];
          ext_z_q <= diff_z[bba_pkg::COORD_BITS-1:0];
        end
      end
      bba_pkg::BK_SQUARE: begin
        sq_x_q <= bba_pkg::SQ_BITS'(ext_x_q) * bba_pkg::SQ_BITS'(ext_x_q);
        sq_y_q <= bba_pkg::SQ_BITS'(ext_y_q) * bba_pkg::SQ_BITS'(ext_y_q);
        sq_z_q <= bba_pkg::SQ_BITS'(ext_z_q) * bba_pkg::SQ_BITS'(ext_z_q);
      end
      bba_pkg::BK_SUM: begin
        rad_q  <= sum[bba_pkg::SUM_BITS-1:2];
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= bba_pkg::CNT_BITS'(bba_pkg::COORD_BITS - 1);
      end
      bba_pkg::BK_ROOT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= fits ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[bba_pkg::COORD_BITS-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
      end
      bba_pkg::BK_OUT: ;
      default: ;
    endcase
  end

  assign m_axis_tvalid = (state_q == bba_pkg::BK_OUT);
  assign m_axis_tdata  = bba_pkg::OUT_TDATA_W'({root_q, box_q});

endmodule
